// ===== rtl/fsmi_pkg.sv =====
// ============================================================================
// fsmi_pkg
// Shared widths, codes and types of the Fermi sea momentum integral pipeline.
// ============================================================================
package fsmi_pkg;

    localparam int MW      = 24;          // mass / momentum, unsigned Q12.12
    localparam int EW      = 25;          // E = isqrt(M*M + P*P)
    localparam int SQ_IW   = 49;          // radicand width
    localparam int M2W     = 36;          // m^2 and p^2 in Q12
    localparam int M4W     = 60;          // m^4 and p^4 in Q12
    localparam int LG_IW   = 26;          // log2 argument width (P + E)
    localparam int LG_FRAC = 30;          // log2 fraction bits
    localparam int LGW     = 35;          // log2 result width, Q30
    localparam int NUMW    = 67;          // signed numerator width
    localparam int VALW    = 64;          // result width, signed Q51.12

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic [1:0] MODE_F0 = 2'd0;
    localparam logic [1:0] MODE_F2 = 2'd1;
    localparam logic [1:0] MODE_FE = 2'd2;

    // How the log term enters the numerator
    typedef enum logic [1:0] {
        K_NONE,
        K_NEG1,
        K_POS3
    } lterm_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       light;   // mass below the tolerance
    } ctl_t;

    typedef struct packed {
        logic signed [NUMW-1:0] val;
        lterm_t                 k;
        logic [1:0]             sh;
    } base_t;

endpackage

// ===== rtl/fermi_sea_momentum_integrals_top.sv =====
// ============================================================================
// fermi_sea_momentum_integrals_top
// Throughput: one beat per cycle; the whole pipeline advances together and
//   holds in place while the output beat is not taken.
// Structure: the 25-stage square root followed by the 31-stage log2 units.
// Reset: rst_n clears all valid bits and sets zero_mass_tolerance to 1.
//   Closed-form momentum integrals F0, F2 and F_E over a Fermi sea.
// ============================================================================
module fermi_sea_momentum_integrals_top
    import fsmi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    // configuration: zero_mass_tolerance, Q12.12
    input  logic            cfg_we,
    input  logic [MW-1:0]   cfg_wdata,
    // input beats
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [47:0]     s_tdata,   // [23:0] mass, [47:24] momentum
    input  logic [1:0]      s_tuser,   // [1:0] mode
    // result beats
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [VALW-1:0] m_tdata,   // [63:0] value, signed Q51.12
    output logic            m_tuser    // [0] saturated
);

    localparam int       LAT    = 66;
    localparam logic [1:0] SH_HALF   = 2'd1;
    localparam logic [1:0] SH_EIGHTH = 2'd3;

    // Global advance: every stage moves when the output slot is free or taken.
    logic            en;
    logic [LAT:1]    vld_reg;
    logic [MW-1:0]   tol_reg;

    // stage 1: input capture and the two square products
    logic [1:0]      mode_s1_reg;
    logic [MW-1:0]   mass_s1_reg;
    logic [MW-1:0]   mom_s1_reg;
    logic            light_s1_reg;
    logic [2*MW-1:0] mm_s1_reg;
    logic [2*MW-1:0] pp_s1_reg;

    // stage 2: radicand and Q12 squares
    ctl_t             ctl_s2_reg;
    logic [MW-1:0]    mass_s2_reg;
    logic [MW-1:0]    mom_s2_reg;
    logic             mzero_s2_reg;
    logic [SQ_IW-1:0] rad_s2_reg;
    logic [M2W-1:0]   m2_s2_reg;
    logic [M2W-1:0]   p2_s2_reg;

    logic [EW-1:0]   e_s27;
    logic [M4W-1:0]  m4_s4;
    logic [47:0]     p3_s4;
    logic [M4W-1:0]  p4_s4;
    ctl_t            ctl_s4;
    logic [M2W-1:0]  m2_s4;
    logic [M2W-1:0]  p2_s4;
    logic [M4W-1:0]  mx_s4;
    logic [M4W-1:0]  mlv_s4;
    logic [M4W-1:0]  mx_s62;
    logic [M4W-1:0]  mlv_s33;
    ctl_t            ctl_s33;
    logic [M2W-1:0]  m2_s29;
    logic [47:0]     p3_s27;
    logic [MW-1:0]   mom_s27;
    logic [MW-1:0]   mass_s28;
    logic            mzero_s59;
    logic [36:0]     pe_s29;
    logic [60:0]     a_s29;
    logic [37:0]     ee_s29;
    logic [EW-1:0]   e_s29;
    logic [MW-1:0]   mom_s31;
    logic [50:0]     e3_s31;
    logic [60:0]     b_s31;
    logic [62:0]     c_s33;
    logic [60:0]     a_s33;
    logic [36:0]     pe_s33;
    logic [60:0]     b_s33;
    base_t           base_next;
    base_t           base_s34_reg;
    base_t           base_s64;
    logic [LG_IW-1:0] spe_s28_reg;
    logic [LGW-1:0]  la_s59;
    logic [LGW-1:0]  lb_s59;
    logic [LGW-1:0]  d_s60_reg;
    logic [LGW-1:0]  l_s62;
    logic [64:0]     term_s64;
    logic [NUMW-1:0] kterm;
    logic signed [NUMW-1:0] num_s65_reg;
    logic [1:0]      sh_s65_reg;
    logic signed [NUMW-1:0] shifted;
    logic [VALW-1:0] value_reg;
    logic            sat_reg;

    assign en       = !vld_reg[LAT] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT];
    assign m_tdata  = value_reg;
    assign m_tuser  = sat_reg;

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            tol_reg <= MW'(1);
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-1:1], s_tvalid};
            end
        end
    end

    // ---------------------------------------------------------- front stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_s1_reg  <= s_tuser;
            mass_s1_reg  <= s_tdata[23:0];
            mom_s1_reg   <= s_tdata[47:24];
            light_s1_reg <= s_tdata[23:0] < tol_reg;
            mm_s1_reg    <= s_tdata[23:0] * s_tdata[23:0];
            pp_s1_reg    <= s_tdata[47:24] * s_tdata[47:24];

            ctl_s2_reg.mode  <= mode_s1_reg;
            ctl_s2_reg.light <= light_s1_reg;
            mass_s2_reg      <= mass_s1_reg;
            mom_s2_reg       <= mom_s1_reg;
            mzero_s2_reg     <= mass_s1_reg == '0;
            rad_s2_reg       <= SQ_IW'(mm_s1_reg) + SQ_IW'(pp_s1_reg);
            m2_s2_reg        <= mm_s1_reg[2*MW-1:12];
            p2_s2_reg        <= pp_s1_reg[2*MW-1:12];
        end
    end

    // E = floor(sqrt(M*M + P*P)), ready at stage 27
    fsmi_sqrt #(.IW(SQ_IW), .NR(EW)) u_sqrt (
        .clk(clk), .en(en), .x(rad_s2_reg), .q(e_s27)
    );

    // products that need no E, ready at stage 4
    fsmi_mul #(.WA(M2W), .WB(M2W), .SH(12), .WO(M4W)) u_m4 (
        .clk(clk), .en(en), .a(m2_s2_reg), .b(m2_s2_reg), .q(m4_s4)
    );
    fsmi_mul #(.WA(M2W), .WB(MW), .SH(12), .WO(48)) u_p3 (
        .clk(clk), .en(en), .a(p2_s2_reg), .b(mom_s2_reg), .q(p3_s4)
    );
    fsmi_mul #(.WA(M2W), .WB(M2W), .SH(12), .WO(M4W)) u_p4 (
        .clk(clk), .en(en), .a(p2_s2_reg), .b(p2_s2_reg), .q(p4_s4)
    );

    fsmi_dly #(.W($bits(ctl_t)), .D(2)) u_d_ctl4 (
        .clk(clk), .en(en), .d(ctl_s2_reg), .q(ctl_s4)
    );
    fsmi_dly #(.W(M2W), .D(2)) u_d_m2_4 (
        .clk(clk), .en(en), .d(m2_s2_reg), .q(m2_s4)
    );
    fsmi_dly #(.W(M2W), .D(2)) u_d_p2_4 (
        .clk(clk), .en(en), .d(p2_s2_reg), .q(p2_s4)
    );

    // Pick the mass power that scales the log term, and the massless form.
    assign mx_s4  = (ctl_s4.mode == MODE_F0) ? M4W'(m2_s4) : m4_s4;
    assign mlv_s4 = (ctl_s4.mode == MODE_F0) ? M4W'(p2_s4 >> 1) : (p4_s4 >> 2);

    fsmi_dly #(.W(M4W), .D(58)) u_d_mx (
        .clk(clk), .en(en), .d(mx_s4), .q(mx_s62)
    );
    fsmi_dly #(.W(M4W), .D(29)) u_d_mlv (
        .clk(clk), .en(en), .d(mlv_s4), .q(mlv_s33)
    );
    fsmi_dly #(.W($bits(ctl_t)), .D(29)) u_d_ctl33 (
        .clk(clk), .en(en), .d(ctl_s4), .q(ctl_s33)
    );
    fsmi_dly #(.W(M2W), .D(25)) u_d_m2_29 (
        .clk(clk), .en(en), .d(m2_s4), .q(m2_s29)
    );
    fsmi_dly #(.W(48), .D(23)) u_d_p3 (
        .clk(clk), .en(en), .d(p3_s4), .q(p3_s27)
    );
    fsmi_dly #(.W(MW), .D(25)) u_d_mom27 (
        .clk(clk), .en(en), .d(mom_s2_reg), .q(mom_s27)
    );
    fsmi_dly #(.W(MW), .D(26)) u_d_mass28 (
        .clk(clk), .en(en), .d(mass_s2_reg), .q(mass_s28)
    );
    fsmi_dly #(.W(1), .D(57)) u_d_mzero (
        .clk(clk), .en(en), .d(mzero_s2_reg), .q(mzero_s59)
    );

    // ------------------------------------------------------ products with E
    fsmi_mul #(.WA(MW), .WB(EW), .SH(12), .WO(37)) u_pe (
        .clk(clk), .en(en), .a(mom_s27), .b(e_s27), .q(pe_s29)
    );
    fsmi_mul #(.WA(48), .WB(EW), .SH(12), .WO(61)) u_a (
        .clk(clk), .en(en), .a(p3_s27), .b(e_s27), .q(a_s29)
    );
    fsmi_mul #(.WA(EW), .WB(EW), .SH(12), .WO(38)) u_ee (
        .clk(clk), .en(en), .a(e_s27), .b(e_s27), .q(ee_s29)
    );
    fsmi_dly #(.W(EW), .D(2)) u_d_e29 (
        .clk(clk), .en(en), .d(e_s27), .q(e_s29)
    );
    fsmi_dly #(.W(MW), .D(4)) u_d_mom31 (
        .clk(clk), .en(en), .d(mom_s27), .q(mom_s31)
    );
    fsmi_mul #(.WA(38), .WB(EW), .SH(12), .WO(51)) u_e3 (
        .clk(clk), .en(en), .a(ee_s29), .b(e_s29), .q(e3_s31)
    );
    fsmi_mul #(.WA(M2W), .WB(37), .SH(12), .WO(61)) u_b (
        .clk(clk), .en(en), .a(m2_s29), .b(pe_s29), .q(b_s31)
    );
    fsmi_mul #(.WA(MW), .WB(51), .SH(12), .WO(63)) u_c (
        .clk(clk), .en(en), .a(mom_s31), .b(e3_s31), .q(c_s33)
    );
    fsmi_dly #(.W(61), .D(4)) u_d_a33 (
        .clk(clk), .en(en), .d(a_s29), .q(a_s33)
    );
    fsmi_dly #(.W(37), .D(4)) u_d_pe33 (
        .clk(clk), .en(en), .d(pe_s29), .q(pe_s33)
    );
    fsmi_dly #(.W(61), .D(2)) u_d_b33 (
        .clk(clk), .en(en), .d(b_s31), .q(b_s33)
    );

    // Numerator without the log term; the log term joins later with
    // weight -1 (F0, F_E) or +3 (F2). Massless and unused modes carry no
    // log term and no final shift.
    always_comb
    begin
        base_next.val = '0;
        base_next.k   = K_NONE;
        base_next.sh  = 2'd0;
        case (ctl_s33.mode)
            MODE_F0:
            begin
                if (ctl_s33.light)
                begin
                    base_next.val = NUMW'(mlv_s33);
                end
                else
                begin
                    base_next.val = NUMW'(pe_s33);
                    base_next.k   = K_NEG1;
                    base_next.sh  = SH_HALF;
                end
            end
            MODE_F2:
            begin
                if (ctl_s33.light)
                begin
                    base_next.val = NUMW'(mlv_s33);
                end
                else
                begin
                    base_next.val = (NUMW'(a_s33) << 1) - (NUMW'(b_s33) << 1)
                                  - NUMW'(b_s33);
                    base_next.k   = K_POS3;
                    base_next.sh  = SH_EIGHTH;
                end
            end
            MODE_FE:
            begin
                if (ctl_s33.light)
                begin
                    base_next.val = NUMW'(mlv_s33);
                end
                else
                begin
                    base_next.val = (NUMW'(c_s33) << 1) - NUMW'(b_s33);
                    base_next.k   = K_NEG1;
                    base_next.sh  = SH_EIGHTH;
                end
            end
            default:
            begin
                base_next.val = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_s34_reg <= base_next;
            spe_s28_reg  <= LG_IW'(mom_s27) + LG_IW'(e_s27);
        end
    end

    fsmi_dly #(.W($bits(base_t)), .D(30)) u_d_base (
        .clk(clk), .en(en), .d(base_s34_reg), .q(base_s64)
    );

    // ------------------------------------------------------------ log path
    fsmi_log2 #(.IW(LG_IW), .FRAC(LG_FRAC)) u_lg_pe (
        .clk(clk), .en(en), .x(spe_s28_reg), .q(la_s59)
    );
    fsmi_log2 #(.IW(LG_IW), .FRAC(LG_FRAC)) u_lg_m (
        .clk(clk), .en(en), .x(LG_IW'(mass_s28)), .q(lb_s59)
    );

    // Clamp a negative difference to zero; zero mass drops the log term.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (mzero_s59 || (la_s59 <= lb_s59))
            begin
                d_s60_reg <= '0;
            end
            else
            begin
                d_s60_reg <= la_s59 - lb_s59;
            end
        end
    end

    fsmi_mul #(.WA(LGW), .WB(30), .SH(30), .WO(LGW)) u_ln (
        .clk(clk), .en(en), .a(d_s60_reg), .b(LN2_Q30), .q(l_s62)
    );
    fsmi_mul #(.WA(M4W), .WB(LGW), .SH(30), .WO(65)) u_term (
        .clk(clk), .en(en), .a(mx_s62), .b(l_s62), .q(term_s64)
    );

    // ------------------------------------------------------ combine, round
    always_comb
    begin
        case (base_s64.k)
            K_POS3:  kterm = NUMW'(term_s64) + (NUMW'(term_s64) << 1);
            K_NEG1:  kterm = NUMW'(0) - NUMW'(term_s64);
            default: kterm = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_s65_reg <= base_s64.val + kterm;
            sh_s65_reg  <= base_s64.sh;
        end
    end

    // Arithmetic shift floors toward minus infinity; clip to 64 bits.
    assign shifted = num_s65_reg >>> sh_s65_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if ((shifted[NUMW-1:VALW-1] == '0) || (shifted[NUMW-1:VALW-1] == '1))
            begin
                value_reg <= shifted[VALW-1:0];
                sat_reg   <= 1'b0;
            end
            else
            begin
                value_reg <= shifted[NUMW-1] ? {1'b1, {(VALW-1){1'b0}}}
                                             : {1'b0, {(VALW-1){1'b1}}};
                sat_reg   <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------ checks
    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            (m_tdata == {1'b1, {(VALW-1){1'b0}}}) ||
            (m_tdata == {1'b0, {(VALW-1){1'b1}}}))
        else $error("saturated beat carries a non-extreme value");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved while stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[1])
        else $error("accepted beat did not enter the pipeline");

    a_mode3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[64] && (base_s64.k == K_NONE) && (base_s64.val == '0)
            |=> num_s65_reg == '0)
        else $error("empty numerator picked up a log term");

endmodule

// ===== rtl/fsmi_dly.sv =====
// ============================================================================
// fsmi_dly
// Stall-aware delay line that keeps side data aligned with the pipeline.
// ============================================================================
module fsmi_dly
    import fsmi_pkg::*;
#(
    parameter int W = MW,
    parameter int D = 1
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [D];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0] <= d;
            for (int i = 1; i < D; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[D-1];

endmodule

// ===== rtl/fsmi_mul.sv =====
// ============================================================================
// fsmi_mul
// Two-stage multiplier: four registered half products, then sum and shift.
// ============================================================================
module fsmi_mul
    import fsmi_pkg::*;
#(
    parameter int WA = M2W,
    parameter int WB = M2W,
    parameter int SH = 12,
    parameter int WO = M4W
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [WA-1:0] a,
    input  logic [WB-1:0] b,
    output logic [WO-1:0] q
);

    localparam int HA = (WA + 1) / 2;
    localparam int HB = (WB + 1) / 2;
    localparam int FW = WA + WB;

    logic [HA+HB-1:0]           pll_reg;
    logic [HA+WB-HB-1:0]        plh_reg;
    logic [WA-HA+HB-1:0]        phl_reg;
    logic [WA-HA+WB-HB-1:0]     phh_reg;
    logic [FW-1:0]              sum;
    logic [WO-1:0]              q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg <= a[HA-1:0]  * b[HB-1:0];
            plh_reg <= a[HA-1:0]  * b[WB-1:HB];
            phl_reg <= a[WA-1:HA] * b[HB-1:0];
            phh_reg <= a[WA-1:HA] * b[WB-1:HB];
        end
    end

    assign sum = FW'(pll_reg) + (FW'(plh_reg) << HB) + (FW'(phl_reg) << HA)
               + (FW'(phh_reg) << (HA + HB));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= WO'(sum >> SH);
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/fsmi_sqrt.sv =====
// ============================================================================
// fsmi_sqrt
// Pipelined integer square root, one root bit per stage, floored.
// ============================================================================
module fsmi_sqrt
    import fsmi_pkg::*;
#(
    parameter int IW = SQ_IW,
    parameter int NR = (IW + 1) / 2
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [IW-1:0] x,
    output logic [NR-1:0] q
);

    localparam int XW = 2 * NR;
    localparam int RW = NR + 4;

    logic [RW-1:0] rem_reg  [NR];
    logic [NR-1:0] root_reg [NR];
    logic [XW-1:0] xs_reg   [NR];
    logic [RW-1:0] rem_next  [NR];
    logic [NR-1:0] root_next [NR];
    logic [XW-1:0] xs_next   [NR];

    always_comb
    begin
        logic [RW-1:0] rem_s;
        logic [NR-1:0] root_s;
        logic [XW-1:0] xs_s;
        logic [RW-1:0] r2;
        logic [RW-1:0] t;
        for (int j = 0; j < NR; j++)
        begin
            if (j == 0)
            begin
                rem_s  = '0;
                root_s = '0;
                xs_s   = XW'(x);
            end
            else
            begin
                rem_s  = rem_reg[j-1];
                root_s = root_reg[j-1];
                xs_s   = xs_reg[j-1];
            end
            // bring down the next radicand pair and try the new root bit
            r2 = (rem_s << 2) | RW'(xs_s[XW-1:XW-2]);
            t  = RW'({root_s, 2'b01});
            if (r2 >= t)
            begin
                rem_next[j]  = r2 - t;
                root_next[j] = {root_s[NR-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = r2;
                root_next[j] = {root_s[NR-2:0], 1'b0};
            end
            xs_next[j] = xs_s << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NR; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                xs_reg[j]   <= xs_next[j];
            end
        end
    end

    assign q = root_reg[NR-1];

endmodule

// ===== rtl/fsmi_log2.sv =====
// ============================================================================
// fsmi_log2
// Pipelined log2 in Q(FRAC): normalize, then one squaring per fraction bit.
// ============================================================================
module fsmi_log2
    import fsmi_pkg::*;
#(
    parameter int IW   = LG_IW,
    parameter int FRAC = LG_FRAC,
    parameter int KW   = $clog2(IW),
    parameter int OW   = KW + FRAC
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [IW-1:0] x,
    output logic [OW-1:0] q
);

    localparam int YW = FRAC + 1;
    localparam int SW = 2 * YW;

    logic [YW-1:0]   y_reg  [FRAC+1];
    logic [FRAC-1:0] f_reg  [FRAC+1];
    logic [KW-1:0]   k_reg  [FRAC+1];
    logic [YW-1:0]   y_next [FRAC+1];
    logic [FRAC-1:0] f_next [FRAC+1];
    logic [KW-1:0]   k_next [FRAC+1];

    always_comb
    begin
        logic [KW-1:0] k0;
        logic [SW-1:0] sq;
        logic [YW:0]   sh;
        // integer part: index of the top set bit
        k0 = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (x[i])
            begin
                k0 = KW'(i);
            end
        end
        y_next[0] = YW'(x) << (FRAC - int'(k0));
        f_next[0] = '0;
        k_next[0] = k0;
        for (int j = 1; j <= FRAC; j++)
        begin
            sq        = SW'(y_reg[j-1]) * SW'(y_reg[j-1]);
            sh        = sq[SW-1:FRAC];
            f_next[j] = f_reg[j-1];
            k_next[j] = k_reg[j-1];
            if (sh[YW])
            begin
                y_next[j]          = sh[YW:1];
                f_next[j][FRAC-j]  = 1'b1;
            end
            else
            begin
                y_next[j] = sh[YW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j <= FRAC; j++)
            begin
                y_reg[j] <= y_next[j];
                f_reg[j] <= f_next[j];
                k_reg[j] <= k_next[j];
            end
        end
    end

    assign q = {k_reg[FRAC], f_reg[FRAC]};

endmodule

// ===== verif/fermi_sea_momentum_integrals_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// fermi_sea_momentum_integrals_checker
// Watches the input, output and configuration ports of the integral pipeline.
// Computes the expected value and saturation flag of every accepted input
// beat, then compares each output beat with the oldest pending result.
// ============================================================================
module fermi_sea_momentum_integrals_checker
    import fsmi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [MW-1:0]   cfg_wdata,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  logic [47:0]     s_tdata,
    input  logic [1:0]      s_tuser,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [VALW-1:0] m_tdata,
    input  logic            m_tuser,
    output int              errors,
    output int              pending,
    output int              results_seen
);

    typedef struct packed {
        logic [63:0] value;
        logic        sat;
    } integral_t;

    integral_t   integral_q[$];
    logic [23:0] tolerance;

    function automatic logic [63:0] mshr(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod >> s;
        if (prod[127:64] != 0)
            return '1;
        return prod[63:0];
    endfunction

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] log2_q30(logic [63:0] x);
        int          k;
        logic [63:0] y;
        logic [63:0] res;
        k = 0;
        while (k < 63 && (x >> (k + 1)) != 0)
            k++;
        y   = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
        res = 64'(k) << 30;
        for (int i = 29; i >= 0; i--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31))
            begin
                y = y >> 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic integral_t integrate(logic [1:0] md, logic [23:0] ms,
                                            logic [23:0] mo);
        integral_t   r;
        logic [63:0] mm, pp, e, m2, m4, pe, lnv, pos, neg, t, p2, d, mag;
        int          sh;
        mm  = 64'(ms);
        pp  = 64'(mo);
        r   = '0;
        lnv = 0;
        if (md == 2'd3)
            return r;
        if (mm < 64'(tolerance))
        begin
            p2 = (pp * pp) >> 12;
            r.value = (md == MODE_F0) ? (p2 >> 1) : (mshr(p2, p2, 12) >> 2);
            return r;
        end
        e  = root(mm * mm + pp * pp);
        m2 = (mm * mm) >> 12;
        m4 = mshr(m2, m2, 12);
        pe = (pp * e) >> 12;
        if (mm != 0 && pp + e != 0)
        begin
            t = log2_q30(pp + e);
            d = log2_q30(mm);
            d = (t > d) ? t - d : 0;
            lnv = mshr(d, 64'(LN2_Q30), 30);
        end
        if (md == MODE_F0)
        begin
            pos = pe;
            neg = mshr(m2, lnv, 30);
            sh  = 1;
        end
        else if (md == MODE_F2)
        begin
            t   = mshr(mshr(mshr(pp, pp, 12), pp, 12), e, 12);
            pos = sadd(t, t);
            t   = mshr(m4, lnv, 30);
            pos = sadd(pos, sadd(sadd(t, t), t));
            t   = mshr(m2, pe, 12);
            neg = sadd(sadd(t, t), t);
            sh  = 3;
        end
        else
        begin
            t   = mshr(pp, mshr(mshr(e, e, 12), e, 12), 12);
            pos = sadd(t, t);
            neg = sadd(mshr(m2, pe, 12), mshr(m4, lnv, 30));
            sh  = 3;
        end
        if (pos >= neg)
        begin
            mag = (pos - neg) >> sh;
            if (mag > 64'h7FFF_FFFF_FFFF_FFFF)
            begin
                mag   = 64'h7FFF_FFFF_FFFF_FFFF;
                r.sat = 1'b1;
            end
            r.value = mag;
        end
        else
        begin
            d   = neg - pos;
            mag = (d >> sh) + (((d & ((64'd1 << sh) - 1)) != 0) ? 64'd1 : 64'd0);
            if (mag > (64'd1 << 63))
            begin
                mag   = 64'd1 << 63;
                r.sat = 1'b1;
            end
            r.value = 64'd0 - mag;
        end
        return r;
    endfunction

    assign pending = integral_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        integral_t want;
        if (!rst_n)
        begin
            tolerance    <= 24'd1;
            errors       <= 0;
            results_seen <= 0;
            integral_q.delete();
        end
        else
        begin
            // the beat that coincides with a register write still sees the old value
            if (s_tvalid && s_tready)
                integral_q.push_back(integrate(s_tuser, s_tdata[23:0], s_tdata[47:24]));
            if (cfg_we)
                tolerance <= cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (integral_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result beat value=%h sat=%b", m_tdata, m_tuser);
                    errors <= errors + 1;
                end
                else
                begin
                    want = integral_q.pop_front();
                    if (want.value !== m_tdata || want.sat !== m_tuser)
                    begin
                        if (errors < 10)
                            $display("mismatch: want value=%h sat=%b, got value=%h sat=%b",
                                     want.value, want.sat, m_tdata, m_tuser);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/fermi_sea_momentum_integrals_top_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// fermi_sea_momentum_integrals_top_test
// Drives directed corner beats and random mass/momentum/mode beats through
// the integral pipeline under several tolerance settings, with random gaps
// and output stalls; a separate checker predicts and compares every result.
// ============================================================================
module fermi_sea_momentum_integrals_top_test;
    import fsmi_pkg::*;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [MW-1:0]   cfg_wdata = '0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [47:0]     s_tdata = '0;
    logic [1:0]      s_tuser = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [VALW-1:0] m_tdata;
    logic            m_tuser;

    int errors, pending, results_seen;
    int beats_sent = 0;
    bit calm = 1'b0;     // set during the stretch with no idling on either side

    always #1 clk = ~clk;

    fermi_sea_momentum_integrals_top dut (
        .clk, .rst_n, .cfg_we, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    fermi_sea_momentum_integrals_checker checker_i (
        .clk, .rst_n, .cfg_we, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .errors, .pending, .results_seen
    );

    // Stall the result side at random, with odds of about 8 in 100, except when calm.
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 8);

    // Send one beat, idling first at random; hold it until it is taken.
    task automatic send_beat(logic [1:0] md, logic [23:0] ms, logic [23:0] mo);
        while (!calm && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {mo, ms};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    // Drain the pipeline, let the latency pass, then write the tolerance.
    task automatic set_tolerance(logic [23:0] tol);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= tol;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Small or mid-size quantities half the time, full-range values otherwise.
    function automatic logic [23:0] pick_q12();
        case ($urandom_range(3))
            0: return 24'($urandom_range(4095));
            1: return 24'($urandom_range(262143));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        // an unused mode code now and then
        return ($urandom_range(49) == 0) ? 2'd3 : 2'($urandom_range(2));
    endfunction

    initial
    begin
        logic [23:0] tols [5];
        tols = '{24'd0, 24'hFFFFFF, 24'd4096, 24'd1, 24'($urandom)};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners at the reset tolerance of one LSB.
        for (int md = 0; md < 4; md++)
        begin
            send_beat(2'(md), 24'd0, 24'd0);
            send_beat(2'(md), 24'hFFFFFF, 24'hFFFFFF);
            send_beat(2'(md), 24'd1, 24'hFFFFFF);
            send_beat(2'(md), 24'hFFFFFF, 24'd0);
            send_beat(2'(md), 24'd4096, 24'd4096);
        end
        // zero mass with zero tolerance: log term drops out
        set_tolerance(tols[0]);
        for (int md = 0; md < 3; md++)
            send_beat(2'(md), 24'd0, 24'h123456);

        // Random phases, one per tolerance setting; the third runs without idling.
        for (int ph = 0; ph < 5; ph++)
        begin
            set_tolerance(tols[ph]);
            calm = (ph == 2);
            for (int i = 0; i < 365; i++)
                send_beat(pick_mode(), pick_q12(), pick_q12());
            calm = 1'b0;
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);

        $display("covered %0d input beats and %0d result beats over six tolerance settings",
                 beats_sent, results_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fsmi_pkg.sv
rtl/fsmi_dly.sv
rtl/fsmi_mul.sv
rtl/fsmi_sqrt.sv
rtl/fsmi_log2.sv
rtl/fermi_sea_momentum_integrals_top.sv
verif/fermi_sea_momentum_integrals_checker.sv
verif/fermi_sea_momentum_integrals_top_test.sv
